// ===== hw/rtl/lpmt_pkg.sv =====
`timescale 1ns / 1ps

package lpmt_pkg;

    // Fixed-point format of the rotation coefficients
    localparam int COEF_W         = 16;
    localparam int COEF_FRAC_BITS = 14;
    localparam int COORD_W        = 32;
    localparam int PROD_W         = COEF_W + COORD_W;
    localparam int ROW_W          = 3 * COEF_W;
    localparam int TIME_W         = 64;
    localparam int OFFSET_W       = 32;
    localparam int BYTE_W         = 8;
    localparam int CFG_DATA_W     = ROW_W;
    localparam int CFG_INDEX_W    = 3;
    localparam int FUNC_W         = 2;

    // Item kinds
    localparam logic [FUNC_W-1:0] FUNC_HEADER = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_FRONT  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_BACK   = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_NONE   = 2'd3;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_ROT_ROW0    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ROT_ROW1    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ROT_ROW2    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SHIFT_X     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SHIFT_Y     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_SHIFT_Z     = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_INTERVAL = 3'd6;

    // Identity matrix at reset: a one on the diagonal of each row
    localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1) << COEF_FRAC_BITS;
    localparam logic [ROW_W-1:0] ROW0_RESET = ROW_W'(COEF_ONE);
    localparam logic [ROW_W-1:0] ROW1_RESET = ROW_W'(COEF_ONE) << COEF_W;
    localparam logic [ROW_W-1:0] ROW2_RESET = ROW_W'(COEF_ONE) << (2 * COEF_W);

    typedef struct packed {
        logic can_merge;
        logic drop_front;
    } hdr_flags_t;

endpackage

// ===== hw/rtl/lpmt_rot_row.sv =====
`timescale 1ns / 1ps

module lpmt_rot_row (
    input  logic [lpmt_pkg::ROW_W-1:0]          row,
    input  logic signed [lpmt_pkg::COORD_W-1:0] x,
    input  logic signed [lpmt_pkg::COORD_W-1:0] y,
    input  logic signed [lpmt_pkg::COORD_W-1:0] z,
    input  logic signed [lpmt_pkg::COORD_W-1:0] shift,
    output logic signed [lpmt_pkg::COORD_W-1:0] result
);
    import lpmt_pkg::*;

    localparam int RND_W = PROD_W + 1;
    localparam int SUM_W = RND_W + 2;
    localparam logic signed [RND_W-1:0] ROUND_ADD = RND_W'(1) << (COEF_FRAC_BITS - 1);
    localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'({1'b0, {(COORD_W-1){1'b1}}});
    localparam logic signed [SUM_W-1:0] SAT_MIN = -SAT_MAX - SUM_W'(1);

    logic signed [COEF_W-1:0]  coef [3];
    logic signed [COORD_W-1:0] coord [3];
    logic signed [PROD_W-1:0]  prod [3];
    logic signed [RND_W-1:0]   rnd [3];
    logic signed [SUM_W-1:0]   sum;

    assign coord[0] = x;
    assign coord[1] = y;
    assign coord[2] = z;

    always_comb
    begin
        sum = SUM_W'(shift);
        for (int k = 0; k < 3; k++)
        begin
            coef[k] = row[k*COEF_W +: COEF_W];
            prod[k] = PROD_W'(coef[k]) * PROD_W'(coord[k]);
            // round half up, then drop the fraction bits
            rnd[k]  = RND_W'(prod[k]) + ROUND_ADD;
            sum     = sum + SUM_W'(rnd[k] >>> COEF_FRAC_BITS);
        end
    end

    always_comb
    begin
        priority if (sum > SAT_MAX)
        begin
            result = SAT_MAX[COORD_W-1:0];
        end
        else if (sum < SAT_MIN)
        begin
            result = SAT_MIN[COORD_W-1:0];
        end
        else
        begin
            result = sum[COORD_W-1:0];
        end
    end

endmodule

// ===== hw/rtl/lpmt_time_unit.sv =====
`timescale 1ns / 1ps

module lpmt_time_unit (
    input  logic [lpmt_pkg::TIME_W-1:0]   stamp_ns,
    input  logic [lpmt_pkg::TIME_W-1:0]   front_base_ns,
    input  logic [lpmt_pkg::TIME_W-1:0]   back_base_ns,
    input  logic [lpmt_pkg::OFFSET_W-1:0] gap_limit,
    input  logic [lpmt_pkg::TIME_W-1:0]   timebase,
    output logic [lpmt_pkg::OFFSET_W-1:0] rel_time,
    output lpmt_pkg::hdr_flags_t          flags,
    output logic [lpmt_pkg::TIME_W-1:0]   new_timebase
);
    import lpmt_pkg::*;

    logic              front_le_back;
    logic [TIME_W-1:0] gap;
    logic [TIME_W-1:0] diff;

    // Header: earlier base time and the absolute gap
    assign front_le_back  = (front_base_ns <= back_base_ns);
    assign gap            = front_le_back ? (back_base_ns - front_base_ns)
                                          : (front_base_ns - back_base_ns);
    assign new_timebase   = front_le_back ? front_base_ns : back_base_ns;
    assign flags.drop_front = front_le_back;
    assign flags.can_merge  = (gap <= TIME_W'(gap_limit));

    // Point: clamp at zero, saturate at the top of the offset range
    assign diff = stamp_ns - timebase;

    always_comb
    begin
        priority if (stamp_ns <= timebase)
        begin
            rel_time = '0;
        end
        else if (diff[TIME_W-1:OFFSET_W] != '0)
        begin
            rel_time = '1;
        end
        else
        begin
            rel_time = diff[OFFSET_W-1:0];
        end
    end

endmodule

// ===== hw/rtl/lidar_point_merge_transform_unit.sv =====
`timescale 1ns / 1ps
// An accepted item goes to the input register, then to the result register.
// Throughput: one item per cycle while in_stall is low; in_stall rises only when
// both the input register and the result register are full and out_stall is high.
// Items of kind 3 are accepted and dropped, they produce no result.
// Reset (rst_n low, asynchronous) empties both stages, clears the timebase and
// loads the identity rotation, zero translation and a zero merge limit.

module lidar_point_merge_transform_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,

    // configuration write port
    input  logic                                  cfg_we,
    input  logic [lpmt_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [lpmt_pkg::CFG_DATA_W-1:0]       cfg_data,

    // input item channel
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [lpmt_pkg::FUNC_W-1:0]           func,
    input  logic signed [lpmt_pkg::COORD_W-1:0]   x,
    input  logic signed [lpmt_pkg::COORD_W-1:0]   y,
    input  logic signed [lpmt_pkg::COORD_W-1:0]   z,
    input  logic [lpmt_pkg::BYTE_W-1:0]           intensity,
    input  logic [lpmt_pkg::BYTE_W-1:0]           tag,
    input  logic [lpmt_pkg::BYTE_W-1:0]           line,
    input  logic [lpmt_pkg::TIME_W-1:0]           stamp_ns,
    input  logic [lpmt_pkg::TIME_W-1:0]           front_base_ns,
    input  logic [lpmt_pkg::TIME_W-1:0]           back_base_ns,

    // result item channel
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [lpmt_pkg::COORD_W-1:0]   out_x,
    output logic signed [lpmt_pkg::COORD_W-1:0]   out_y,
    output logic signed [lpmt_pkg::COORD_W-1:0]   out_z,
    output logic [lpmt_pkg::BYTE_W-1:0]           reflectivity,
    output logic [lpmt_pkg::BYTE_W-1:0]           out_tag,
    output logic [lpmt_pkg::BYTE_W-1:0]           out_line,
    output logic [lpmt_pkg::OFFSET_W-1:0]         rel_time,
    output logic                                  can_merge,
    output logic                                  drop_front,
    output logic [lpmt_pkg::TIME_W-1:0]           merged_timebase
);
    import lpmt_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [ROW_W-1:0]          rot_row_reg [3];
    logic signed [COORD_W-1:0] shift_reg [3];
    logic [OFFSET_W-1:0]       max_interval_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_row_reg[0]   <= ROW0_RESET;
            rot_row_reg[1]   <= ROW1_RESET;
            rot_row_reg[2]   <= ROW2_RESET;
            shift_reg[0]     <= '0;
            shift_reg[1]     <= '0;
            shift_reg[2]     <= '0;
            max_interval_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ROT_ROW0:     rot_row_reg[0]   <= cfg_data;
                REG_ROT_ROW1:     rot_row_reg[1]   <= cfg_data;
                REG_ROT_ROW2:     rot_row_reg[2]   <= cfg_data;
                REG_SHIFT_X:      shift_reg[0]     <= cfg_data[COORD_W-1:0];
                REG_SHIFT_Y:      shift_reg[1]     <= cfg_data[COORD_W-1:0];
                REG_SHIFT_Z:      shift_reg[2]     <= cfg_data[COORD_W-1:0];
                REG_MAX_INTERVAL: max_interval_reg <= cfg_data[OFFSET_W-1:0];
                default:          ; // no register at this index: drop the write
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake: input register (stage 1) feeding the result register
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic s1_valid_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic out_free;
    logic in_accept;
    logic s1_move;

    // result register can take a new item when it is empty or being drained
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = s1_valid_reg && !out_free;
    assign in_accept = in_valid && !in_stall;
    assign s1_move   = s1_valid_reg && out_free;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
        begin
            // kind 3 carries nothing: take it off the channel and drop it
            s1_valid_next = (func != FUNC_NONE);
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_move)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Stage 1 payload, loaded on every accepted item
    logic [FUNC_W-1:0]         s1_func_reg;
    logic signed [COORD_W-1:0] s1_x_reg;
    logic signed [COORD_W-1:0] s1_y_reg;
    logic signed [COORD_W-1:0] s1_z_reg;
    logic [BYTE_W-1:0]         s1_intensity_reg;
    logic [BYTE_W-1:0]         s1_tag_reg;
    logic [BYTE_W-1:0]         s1_line_reg;
    logic [TIME_W-1:0]         s1_stamp_reg;
    logic [TIME_W-1:0]         s1_front_base_reg;
    logic [TIME_W-1:0]         s1_back_base_reg;

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_func_reg       <= func;
            s1_x_reg          <= x;
            s1_y_reg          <= y;
            s1_z_reg          <= z;
            s1_intensity_reg  <= intensity;
            s1_tag_reg        <= tag;
            s1_line_reg       <= line;
            s1_stamp_reg      <= stamp_ns;
            s1_front_base_reg <= front_base_ns;
            s1_back_base_reg  <= back_base_ns;
        end
    end

    // ------------------------------------------------------------------
    // Datapath between stage 1 and the result register
    // ------------------------------------------------------------------
    logic signed [COORD_W-1:0] rot [3];

    for (genvar r = 0; r < 3; r++)
    begin : g_row
        lpmt_rot_row u_row (
            .row    (rot_row_reg[r]),
            .x      (s1_x_reg),
            .y      (s1_y_reg),
            .z      (s1_z_reg),
            .shift  (shift_reg[r]),
            .result (rot[r])
        );
    end

    logic [TIME_W-1:0]   timebase_reg;
    logic [TIME_W-1:0]   timebase_next;
    logic [TIME_W-1:0]   hdr_timebase;
    logic [OFFSET_W-1:0] pt_offset;
    hdr_flags_t          hdr_flags;

    lpmt_time_unit u_time (
        .stamp_ns      (s1_stamp_reg),
        .front_base_ns (s1_front_base_reg),
        .back_base_ns  (s1_back_base_reg),
        .gap_limit     (max_interval_reg),
        .timebase      (timebase_reg),
        .rel_time      (pt_offset),
        .flags         (hdr_flags),
        .new_timebase  (hdr_timebase)
    );

    logic s1_is_header;
    assign s1_is_header = (s1_func_reg == FUNC_HEADER);

    // A header moves the timebase as it leaves stage 1; the point right
    // behind it then sees the new value.
    assign timebase_next = (s1_move && s1_is_header) ? hdr_timebase : timebase_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timebase_reg <= '0;
        end
        else
        begin
            timebase_reg <= timebase_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic signed [COORD_W-1:0] out_x_reg;
    logic signed [COORD_W-1:0] out_y_reg;
    logic signed [COORD_W-1:0] out_z_reg;
    logic [BYTE_W-1:0]         reflectivity_reg;
    logic [BYTE_W-1:0]         out_tag_reg;
    logic [BYTE_W-1:0]         out_line_reg;
    logic [OFFSET_W-1:0]       rel_time_reg;
    hdr_flags_t                flags_reg;
    logic [TIME_W-1:0]         merged_timebase_reg;

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            merged_timebase_reg <= timebase_next;
            unique case (s1_func_reg)
                FUNC_HEADER:
                begin
                    // header result: flags and timebase only
                    out_x_reg        <= '0;
                    out_y_reg        <= '0;
                    out_z_reg        <= '0;
                    reflectivity_reg <= '0;
                    out_tag_reg      <= '0;
                    out_line_reg     <= '0;
                    rel_time_reg     <= '0;
                    flags_reg        <= hdr_flags;
                end
                FUNC_FRONT:
                begin
                    // front point passes through as is
                    out_x_reg        <= s1_x_reg;
                    out_y_reg        <= s1_y_reg;
                    out_z_reg        <= s1_z_reg;
                    reflectivity_reg <= s1_intensity_reg;
                    out_tag_reg      <= s1_tag_reg;
                    out_line_reg     <= s1_line_reg;
                    rel_time_reg     <= pt_offset;
                    flags_reg        <= '0;
                end
                default:
                begin
                    // back point: rotated and shifted into the front frame
                    out_x_reg        <= rot[0];
                    out_y_reg        <= rot[1];
                    out_z_reg        <= rot[2];
                    reflectivity_reg <= s1_intensity_reg;
                    out_tag_reg      <= s1_tag_reg;
                    out_line_reg     <= s1_line_reg;
                    rel_time_reg     <= pt_offset;
                    flags_reg        <= '0;
                end
            endcase
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_x           = out_x_reg;
    assign out_y           = out_y_reg;
    assign out_z           = out_z_reg;
    assign reflectivity    = reflectivity_reg;
    assign out_tag         = out_tag_reg;
    assign out_line        = out_line_reg;
    assign rel_time        = rel_time_reg;
    assign can_merge       = flags_reg.can_merge;
    assign drop_front      = flags_reg.drop_front;
    assign merged_timebase = merged_timebase_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // the timebase cannot move while a result is still held
    a_timebase_matches: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (merged_timebase_reg == timebase_reg))
        else $error("held result timebase differs from stored timebase");

    // back-pressure only when both stages are full
    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled with room in the pipeline");

    // a point result with a nonzero offset never carries header flags
    a_offset_is_point: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (rel_time_reg != '0)) |-> (flags_reg == '0))
        else $error("point result carries header flags");

    // stage 1 moving on always fills the result register
    a_move_fills: assert property (@(posedge clk) disable iff (!rst_n)
        s1_move |=> out_valid_reg)
        else $error("item lost between stage 1 and result register");

endmodule
